FILE: rtl/ddrc_pkg.sv
`timescale 1ns / 1ps

package ddrc_pkg;

	// Geometry defaults
	localparam int CYLINDERS_DEF = 203;
	localparam int SECTORS_DEF   = 12;

	// Request codes
	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_TICK  = 2'd2
	} req_type_t;

	// Register select codes
	localparam logic [1:0] REG_CSR = 2'd0;
	localparam logic [1:0] REG_WC  = 2'd1;
	localparam logic [1:0] REG_BA  = 2'd2;
	localparam logic [1:0] REG_DA  = 2'd3;

	// Control/status fields
	localparam logic [2:0]  FUNC_READ = 3'd2;
	localparam logic [15:0] READY_BIT = 16'o000200;
	localparam logic [15:0] GO_CLEAR  = 16'o177776;

	// Command start, from the register block to the engine
	typedef struct packed {
		logic        start;
		logic        done;
		logic [15:0] count;
		logic [15:0] addr;
		logic [15:0] disk;
	} cmd_t;

	// Engine status, back to the register block and the result stage
	typedef struct packed {
		logic active;
		logic xfer;
		logic finish;
	} xfer_stat_t;

	// Location of the next word
	typedef struct packed {
		logic [2:0] drive;
		logic [7:0] cylinder;
		logic       surface;
		logic [3:0] sector;
		logic [7:0] word;
	} loc_t;

endpackage

FILE: rtl/ddrc_if.sv
`timescale 1ns / 1ps

interface ddrc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [1:0]  reg_sel;
	logic [15:0] write_data;
	logic [15:0] disk_data;

	modport source (output valid, req_type, reg_sel, write_data, disk_data, input ready);
	modport sink   (input valid, req_type, reg_sel, write_data, disk_data, output ready);
	modport monitor (input valid, ready, req_type, reg_sel, write_data, disk_data);
endinterface

interface ddrc_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic        mem_write_valid;
	logic [15:0] mem_addr;
	logic [15:0] mem_data;
	logic [2:0]  loc_drive;
	logic [7:0]  loc_cylinder;
	logic        loc_surface;
	logic [3:0]  loc_sector;
	logic [7:0]  loc_word;
	logic        busy_res;
	logic        done_res;

	modport source (output valid, read_data, mem_write_valid, mem_addr, mem_data,
		loc_drive, loc_cylinder, loc_surface, loc_sector, loc_word, busy_res, done_res,
		input ready);
	modport sink (input valid, read_data, mem_write_valid, mem_addr, mem_data,
		loc_drive, loc_cylinder, loc_surface, loc_sector, loc_word, busy_res, done_res,
		output ready);
	modport monitor (input valid, ready, read_data, mem_write_valid, mem_addr, mem_data,
		loc_drive, loc_cylinder, loc_surface, loc_sector, loc_word, busy_res, done_res);
endinterface

FILE: rtl/ddrc_regs.sv
`timescale 1ns / 1ps

module ddrc_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [1:0]          req_type,
	input  logic [1:0]          reg_sel,
	input  logic [15:0]         write_data,
	input  ddrc_pkg::xfer_stat_t stat,
	output logic [15:0]         read_data,
	output ddrc_pkg::cmd_t      cmd
);

	logic [15:0] csr_q;
	logic [15:0] wc_q;
	logic [15:0] ba_q;
	logic [15:0] da_q;
	logic [15:0] csr_nxt;
	logic        wr;
	logic        tick;
	logic        go;

	assign wr   = step && (req_type == ddrc_pkg::REQ_WRITE);
	assign tick = step && (req_type == ddrc_pkg::REQ_TICK);
	assign go   = tick && !stat.active && csr_q[0];

	always_comb begin
		read_data = '0;
		if (req_type == ddrc_pkg::REQ_READ) begin
			case (reg_sel)
				ddrc_pkg::REG_CSR: read_data = csr_q;
				ddrc_pkg::REG_WC:  read_data = wc_q;
				ddrc_pkg::REG_BA:  read_data = ba_q;
				ddrc_pkg::REG_DA:  read_data = da_q;
				default:           read_data = '0;
			endcase
		end
	end

	always_comb begin
		cmd.start = 1'b0;
		cmd.done  = 1'b0;
		cmd.count = wc_q;
		cmd.addr  = ba_q;
		cmd.disk  = da_q;
		csr_nxt   = csr_q;
		if (wr && (reg_sel == ddrc_pkg::REG_CSR)) begin
			csr_nxt = write_data;
		end else if (stat.finish) begin
			csr_nxt = csr_q | ddrc_pkg::READY_BIT;
		end else if (go) begin
			// Start a read only with a negative count; anything else completes now
			if ((csr_q[3:1] == ddrc_pkg::FUNC_READ) && wc_q[15]) begin
				cmd.start = 1'b1;
				csr_nxt   = csr_q & ddrc_pkg::GO_CLEAR;
			end else begin
				cmd.done = 1'b1;
				csr_nxt  = (csr_q & ddrc_pkg::GO_CLEAR) | ddrc_pkg::READY_BIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csr_q <= '0;
			wc_q  <= '0;
			ba_q  <= '0;
			da_q  <= '0;
		end else begin
			csr_q <= csr_nxt;
			if (wr && (reg_sel == ddrc_pkg::REG_WC)) wc_q <= write_data;
			if (wr && (reg_sel == ddrc_pkg::REG_BA)) ba_q <= write_data;
			if (wr && (reg_sel == ddrc_pkg::REG_DA)) da_q <= write_data;
		end
	end

endmodule

FILE: rtl/ddrc_xfer.sv
`timescale 1ns / 1ps

module ddrc_xfer #(
	parameter int CYLINDERS         = ddrc_pkg::CYLINDERS_DEF,
	parameter int SECTORS_PER_TRACK = ddrc_pkg::SECTORS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick,
	input  ddrc_pkg::cmd_t       cmd,
	output ddrc_pkg::xfer_stat_t stat,
	output logic [15:0]          work_addr,
	output logic                 active_nxt,
	output ddrc_pkg::loc_t       loc_out
);

	logic           active_q;
	logic [15:0]    count_q;
	logic [15:0]    addr_q;
	ddrc_pkg::loc_t loc_q;
	ddrc_pkg::loc_t loc_adv;
	ddrc_pkg::loc_t loc_nxt;
	logic [15:0]    count_inc;
	logic           adv;
	logic           word_carry;
	logic [4:0]     sec_inc;
	logic           sec_wrap;
	logic [7:0]     cyl_tab [256];
	logic [3:0]     sec_tab [16];

	// Reported cylinder and sector are the counters modulo the geometry
	for (genvar g = 0; g < 256; g++) begin : g_cyl
		localparam logic [7:0] CylMod = 8'(g % CYLINDERS);
		assign cyl_tab[g] = CylMod;
	end
	for (genvar g = 0; g < 16; g++) begin : g_sec
		localparam logic [3:0] SecMod = 4'(g % SECTORS_PER_TRACK);
		assign sec_tab[g] = SecMod;
	end

	assign adv       = tick && active_q;
	assign count_inc = count_q + 16'd1;

	always_comb begin
		word_carry       = (loc_q.word == 8'hFF);
		sec_inc          = {1'b0, loc_q.sector} + 5'(word_carry);
		sec_wrap         = (sec_inc >= 5'(SECTORS_PER_TRACK));
		loc_adv.drive    = loc_q.drive;
		loc_adv.word     = loc_q.word + 8'd1;
		loc_adv.sector   = sec_wrap ? 4'd0 : sec_inc[3:0];
		loc_adv.surface  = loc_q.surface ^ sec_wrap;
		loc_adv.cylinder = loc_q.cylinder + 8'(sec_wrap && loc_q.surface);
	end

	always_comb begin
		loc_nxt = loc_q;
		if (cmd.start) begin
			loc_nxt.drive    = cmd.disk[15:13];
			loc_nxt.cylinder = cmd.disk[12:5];
			loc_nxt.surface  = cmd.disk[4];
			loc_nxt.sector   = cmd.disk[3:0];
			loc_nxt.word     = '0;
		end else if (adv) begin
			loc_nxt = loc_adv;
		end
	end

	assign stat.active = active_q;
	assign stat.xfer   = adv;
	assign stat.finish = adv && !count_inc[15];
	assign work_addr   = addr_q;
	assign active_nxt  = cmd.start || (active_q && !stat.finish);

	always_comb begin
		loc_out          = loc_nxt;
		loc_out.cylinder = cyl_tab[loc_nxt.cylinder];
		loc_out.sector   = sec_tab[loc_nxt.sector];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			count_q  <= '0;
			addr_q   <= '0;
			loc_q    <= '0;
		end else begin
			active_q <= active_nxt;
			loc_q    <= loc_nxt;
			if (cmd.start) begin
				count_q <= cmd.count;
				addr_q  <= cmd.addr;
			end else if (adv) begin
				count_q <= count_inc;
				addr_q  <= addr_q + 16'd2;
			end
		end
	end

endmodule

FILE: rtl/disk_dma_read_controller.sv
`timescale 1ns / 1ps

// Disk DMA read controller.
// Channel req carries one request per handshake: a register write, a
// register read, or a tick that advances the controller (req_type). On a
// tick during a read transfer, disk_data must hold the word at the location
// reported by the previous result.
// Channel res returns exactly one result per request: read data, the memory
// write (address, data, strobe), the location of the next word, busy and done.
// From request accept to result valid a request passes the input register,
// which loads on the accept edge, and then the result register.
// Throughput is one request per cycle while res.ready holds no result back;
// the register block, transfer engine and location counters all update in
// the single pass between those two registers.
// Reset clears all bus registers, the engine and both stage valid flags;
// the channels come up empty and a request may be taken once reset ends.
// When the receiver holds res.ready low, the result is held, the input stage
// fills, and req.ready drops until the result is taken; nothing is lost.
module disk_dma_read_controller #(
	parameter int CYLINDERS         = ddrc_pkg::CYLINDERS_DEF,
	parameter int SECTORS_PER_TRACK = ddrc_pkg::SECTORS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	ddrc_req_if.sink req,
	ddrc_res_if.source res
);

	logic                 valid_s1;
	logic [1:0]           req_type_s1;
	logic [1:0]           reg_sel_s1;
	logic [15:0]          write_data_s1;
	logic [15:0]          disk_data_s1;
	logic                 advance;
	logic                 step;
	logic                 tick;
	logic [15:0]          read_data;
	ddrc_pkg::cmd_t       cmd;
	ddrc_pkg::xfer_stat_t stat;
	logic [15:0]          work_addr;
	logic                 active_nxt;
	ddrc_pkg::loc_t       loc_out;

	logic                 res_valid_q;
	logic [15:0]          read_data_q;
	logic                 mem_write_valid_q;
	logic [15:0]          mem_addr_q;
	logic [15:0]          mem_data_q;
	ddrc_pkg::loc_t       loc_q;
	logic                 busy_q;
	logic                 done_q;

	assign advance   = !res_valid_q || res.ready;
	assign step      = valid_s1 && advance;
	assign tick      = step && (req_type_s1 == ddrc_pkg::REQ_TICK);
	assign req.ready = advance || !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1   <= req.req_type;
			reg_sel_s1    <= req.reg_sel;
			write_data_s1 <= req.write_data;
			disk_data_s1  <= req.disk_data;
		end
	end

	ddrc_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.req_type   (req_type_s1),
		.reg_sel    (reg_sel_s1),
		.write_data (write_data_s1),
		.stat       (stat),
		.read_data  (read_data),
		.cmd        (cmd)
	);

	ddrc_xfer #(
		.CYLINDERS         (CYLINDERS),
		.SECTORS_PER_TRACK (SECTORS_PER_TRACK)
	) u_xfer (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.cmd        (cmd),
		.stat       (stat),
		.work_addr  (work_addr),
		.active_nxt (active_nxt),
		.loc_out    (loc_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			read_data_q       <= read_data;
			mem_write_valid_q <= stat.xfer;
			mem_addr_q        <= stat.xfer ? work_addr : 16'd0;
			mem_data_q        <= stat.xfer ? disk_data_s1 : 16'd0;
			loc_q             <= loc_out;
			busy_q            <= active_nxt;
			done_q            <= stat.finish || cmd.done;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.read_data       = read_data_q;
	assign res.mem_write_valid = mem_write_valid_q;
	assign res.mem_addr        = mem_addr_q;
	assign res.mem_data        = mem_data_q;
	assign res.loc_drive       = loc_q.drive;
	assign res.loc_cylinder    = loc_q.cylinder;
	assign res.loc_surface     = loc_q.surface;
	assign res.loc_sector      = loc_q.sector;
	assign res.loc_word        = loc_q.word;
	assign res.busy_res        = busy_q;
	assign res.done_res        = done_q;

endmodule

FILE: rtl/ddrc_checker.sv
`timescale 1ns / 1ps

module ddrc_checker #(
	parameter int CYLINDERS         = ddrc_pkg::CYLINDERS_DEF,
	parameter int SECTORS_PER_TRACK = ddrc_pkg::SECTORS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ddrc_req_if.sink   req,
	ddrc_res_if.source res
);

	// A stalled result stays up
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid)
		else $error("result dropped while stalled");

	// A transfer never shows register read data
	a_xfer_no_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.mem_write_valid |-> res.read_data == 16'd0)
		else $error("read data on a transfer");

	// A word moves only while busy or on the completing tick
	a_xfer_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.mem_write_valid |-> res.busy_res || res.done_res)
		else $error("transfer outside an active command");

	// Completion leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.done_res |-> !res.busy_res)
		else $error("busy on completion");

	// Reported location stays inside the geometry
	a_loc_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (32'(res.loc_cylinder) < CYLINDERS) &&
			(32'(res.loc_sector) < SECTORS_PER_TRACK))
		else $error("location out of range");

	// With no result pending the input is open
	a_req_open: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> req.ready)
		else $error("request blocked with the output empty");

endmodule

bind disk_dma_read_controller ddrc_checker #(
	.CYLINDERS         (CYLINDERS),
	.SECTORS_PER_TRACK (SECTORS_PER_TRACK)
) u_ddrc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.res    (res)
);
